/* rtl/core/idss_pkg.sv */
// Shared widths, codes, types and constants of the ignition dwell and spark scheduler.
`default_nettype none
package idss_pkg;

	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned PERIOD_DEF   = 30000000;

	localparam int unsigned FUNC_W      = 2;
	localparam int unsigned CH_W        = 2;
	localparam int unsigned TIME_W      = 25;
	localparam int unsigned RPM_W       = 16;
	localparam int unsigned MV_W        = 15;
	localparam int unsigned DWELL_CFG_W = 13;
	localparam int unsigned DWELL_W     = 14;
	localparam int unsigned LEVELS_W    = 4;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 15;

	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_ONE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_TWO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_THREE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_ONE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TWO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_THREE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_FOUR   = 3'd7;

	localparam logic [MV_W-1:0]        VOLT_ONE_RST    = 15'd11000;
	localparam logic [MV_W-1:0]        VOLT_TWO_RST    = 15'd12500;
	localparam logic [MV_W-1:0]        VOLT_THREE_RST  = 15'd14000;
	localparam logic [DWELL_CFG_W-1:0] DWELL_ONE_RST   = 13'd4500;
	localparam logic [DWELL_CFG_W-1:0] DWELL_TWO_RST   = 13'd3500;
	localparam logic [DWELL_CFG_W-1:0] DWELL_THREE_RST = 13'd3000;
	localparam logic [DWELL_CFG_W-1:0] DWELL_FOUR_RST  = 13'd2800;

	localparam logic [RPM_W-1:0] RPM_HIGH = 16'd8000;
	localparam logic [RPM_W-1:0] RPM_LOW  = 16'd1000;

	// dwell * k / 100 as dwell * (k * ceil(2^27 / 100)) >> 27, exact for these ranges
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned SCALE_W     = 28;
	localparam int unsigned PROD_W      = DWELL_CFG_W + SCALE_W;
	localparam logic [SCALE_W-1:0] SCALE_TRIM  = 28'd114085130;
	localparam logic [SCALE_W-1:0] SCALE_UNITY = 28'd134217800;
	localparam logic [SCALE_W-1:0] SCALE_BOOST = 28'd154350470;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CH_W-1:0]   channel;
		logic [TIME_W-1:0] target_time;
		logic [RPM_W-1:0]  engine_rpm;
		logic [MV_W-1:0]   battery_mv;
	} idss_item_t;

	typedef struct packed {
		logic                   enable;
		logic [MV_W-1:0]        volt_band_one_mv;
		logic [MV_W-1:0]        volt_band_two_mv;
		logic [MV_W-1:0]        volt_band_three_mv;
		logic [DWELL_CFG_W-1:0] dwell_band_one_us;
		logic [DWELL_CFG_W-1:0] dwell_band_two_us;
		logic [DWELL_CFG_W-1:0] dwell_band_three_us;
		logic [DWELL_CFG_W-1:0] dwell_band_four_us;
	} idss_cfg_t;

	typedef struct packed {
		logic                accepted;
		logic [LEVELS_W-1:0] coil_levels;
		logic [DWELL_W-1:0]  dwell_used_us;
		logic [TIME_W-1:0]   counter_value;
	} idss_result_t;

endpackage
`default_nettype wire

/* rtl/core/idss_cmd_if.sv */
// Command channel interface: valid/ready plus one input item per beat.
`default_nettype none
interface idss_cmd_if import idss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CH_W-1:0]   channel;
	logic [TIME_W-1:0] target_time;
	logic [RPM_W-1:0]  engine_rpm;
	logic [MV_W-1:0]   battery_mv;

	modport source (output valid, func, channel, target_time, engine_rpm, battery_mv,
		input ready);
	modport sink (input valid, func, channel, target_time, engine_rpm, battery_mv,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/idss_rsp_if.sv */
// Result channel interface: valid/ready plus one result item per beat.
`default_nettype none
interface idss_rsp_if import idss_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                accepted;
	logic [LEVELS_W-1:0] coil_levels;
	logic [DWELL_W-1:0]  dwell_used_us;
	logic [TIME_W-1:0]   counter_value;

	modport source (output valid, accepted, coil_levels, dwell_used_us, counter_value,
		input ready);
	modport sink (input valid, accepted, coil_levels, dwell_used_us, counter_value,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/ignition_dwell_spark_scheduler.sv */
// Ignition dwell and spark scheduler top level.
// A command beat is registered into stage one, then stage two, then the result register that drives the result beat.
// Throughput: one command per cycle while rsp.ready does not stall the output; the counter/compare update is one pass.
// Dwell scaling uses one 13x28 multiply, registered before the channel stage.
// Reset: async active low; counter 0, all channels forced low, registers at defaults.
`default_nettype none
module ignition_dwell_spark_scheduler import idss_pkg::*; #(
	parameter int unsigned CHANNELS       = CHANNELS_DEF,
	parameter int unsigned COUNTER_PERIOD = PERIOD_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	idss_cmd_if.sink                   cmd,
	idss_rsp_if.source                 rsp
);

	idss_cfg_t    cfg;
	idss_item_t   item_s1;
	idss_item_t   item_s2;
	logic [DWELL_W-1:0] dwell_s2;
	logic         v_s1;
	logic         v_s2;
	logic         out_v_q;
	idss_result_t res_d;
	idss_result_t res_q;
	logic         take;
	logic         adv_s1;
	logic         adv_out;

	assign adv_out   = v_s2 && (!out_v_q || rsp.ready);
	assign adv_s1    = v_s1 && (!v_s2 || adv_out);
	assign cmd.ready = !v_s1 || adv_s1;
	assign take      = cmd.valid && cmd.ready;

	idss_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func        <= cmd.func;
			item_s1.channel     <= cmd.channel;
			item_s1.target_time <= cmd.target_time;
			item_s1.engine_rpm  <= cmd.engine_rpm;
			item_s1.battery_mv  <= cmd.battery_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	idss_dwell_calc u_dwell (
		.clk      (clk),
		.load     (adv_s1),
		.item     (item_s1),
		.cfg      (cfg),
		.item_s2  (item_s2),
		.dwell_s2 (dwell_s2)
	);

	idss_channel_bank #(
		.CHANNELS       (CHANNELS),
		.COUNTER_PERIOD (COUNTER_PERIOD)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv_out),
		.item   (item_s2),
		.dwell  (dwell_s2),
		.enable (cfg.enable),
		.result (res_d)
	);

	always_ff @(posedge clk) begin
		if (adv_out) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.accepted      = res_q.accepted;
	assign rsp.coil_levels   = res_q.coil_levels;
	assign rsp.dwell_used_us = res_q.dwell_used_us;
	assign rsp.counter_value = res_q.counter_value;

	a_dwell_only_when_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (res_q.dwell_used_us != '0) |-> res_q.accepted)
		else $error("dwell reported on a rejected beat");

	a_counter_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ({1'b0, res_q.counter_value} < (TIME_W + 1)'(COUNTER_PERIOD)))
		else $error("counter outside its period");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_out |=> v_s2)
		else $error("stage two beat dropped while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> cmd.ready)
		else $error("input stalled with empty stage one");

endmodule
`default_nettype wire

/* rtl/core/idss_cfg_regs.sv */
// Configuration register file with indexed write port.
`default_nettype none
module idss_cfg_regs import idss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  we,
	input  wire logic [CFG_IDX_W-1:0]  index,
	input  wire logic [CFG_DATA_W-1:0] data,
	output idss_cfg_t                  cfg
);

	idss_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable              <= 1'b1;
			cfg_q.volt_band_one_mv    <= VOLT_ONE_RST;
			cfg_q.volt_band_two_mv    <= VOLT_TWO_RST;
			cfg_q.volt_band_three_mv  <= VOLT_THREE_RST;
			cfg_q.dwell_band_one_us   <= DWELL_ONE_RST;
			cfg_q.dwell_band_two_us   <= DWELL_TWO_RST;
			cfg_q.dwell_band_three_us <= DWELL_THREE_RST;
			cfg_q.dwell_band_four_us  <= DWELL_FOUR_RST;
		end else if (we) begin
			unique case (index)
				CFG_ENABLE:      cfg_q.enable              <= data[0];
				CFG_VOLT_ONE:    cfg_q.volt_band_one_mv    <= data[MV_W-1:0];
				CFG_VOLT_TWO:    cfg_q.volt_band_two_mv    <= data[MV_W-1:0];
				CFG_VOLT_THREE:  cfg_q.volt_band_three_mv  <= data[MV_W-1:0];
				CFG_DWELL_ONE:   cfg_q.dwell_band_one_us   <= data[DWELL_CFG_W-1:0];
				CFG_DWELL_TWO:   cfg_q.dwell_band_two_us   <= data[DWELL_CFG_W-1:0];
				CFG_DWELL_THREE: cfg_q.dwell_band_three_us <= data[DWELL_CFG_W-1:0];
				CFG_DWELL_FOUR:  cfg_q.dwell_band_four_us  <= data[DWELL_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/idss_dwell_calc.sv */
// Dwell stage: voltage band pick and rpm scaling, registered into stage two.
`default_nettype none
module idss_dwell_calc import idss_pkg::*; (
	input  wire logic               clk,
	input  wire logic               load,
	input  idss_item_t              item,
	input  idss_cfg_t               cfg,
	output idss_item_t              item_s2,
	output logic [DWELL_W-1:0]      dwell_s2
);

	logic [DWELL_CFG_W-1:0] base;
	logic [SCALE_W-1:0]     scale;
	logic [PROD_W-1:0]      prod;

	always_comb begin
		if (item.battery_mv < cfg.volt_band_one_mv) begin
			base = cfg.dwell_band_one_us;
		end else if (item.battery_mv < cfg.volt_band_two_mv) begin
			base = cfg.dwell_band_two_us;
		end else if (item.battery_mv < cfg.volt_band_three_mv) begin
			base = cfg.dwell_band_three_us;
		end else begin
			base = cfg.dwell_band_four_us;
		end
		if (item.engine_rpm > RPM_HIGH) begin
			scale = SCALE_TRIM;
		end else if (item.engine_rpm < RPM_LOW) begin
			scale = SCALE_BOOST;
		end else begin
			scale = SCALE_UNITY;
		end
		prod = PROD_W'(base) * PROD_W'(scale);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2  <= item;
			dwell_s2 <= prod[RECIP_SHIFT +: DWELL_W];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/idss_channel_bank.sv */
// Counter, per-channel compares and coil levels; resolves one item per beat.
`default_nettype none
module idss_channel_bank import idss_pkg::*; #(
	parameter int unsigned CHANNELS       = CHANNELS_DEF,
	parameter int unsigned COUNTER_PERIOD = PERIOD_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  idss_item_t              item,
	input  wire logic [DWELL_W-1:0] dwell,
	input  wire logic               enable,
	output idss_result_t            result
);

	localparam logic [TIME_W:0] PERIOD = (TIME_W + 1)'(COUNTER_PERIOD);

	logic [TIME_W-1:0]   counter_q;
	logic [TIME_W-1:0]   dwell_cmp_q [CHANNELS];
	logic [TIME_W-1:0]   spark_cmp_q [CHANNELS];
	logic [CHANNELS-1:0] forced_q;
	logic [CHANNELS-1:0] level_q;

	logic [TIME_W:0]     next_cnt;
	logic                wrap;
	logic [TIME_W-1:0]   tick_cnt;
	logic [TIME_W-1:0]   cnt_d;
	logic [TIME_W-1:0]   start_time;
	logic                is_tick;
	logic                is_sched;
	logic                is_stop;
	logic                ch_ok;
	logic                sched_ok;
	logic                stop_ok;
	logic [CHANNELS-1:0] hit;
	logic [CHANNELS-1:0] forced_d;
	logic [CHANNELS-1:0] level_d;
	logic [LEVELS_W-1:0] levels;

	always_comb begin
		is_tick  = 1'b0;
		is_sched = 1'b0;
		is_stop  = 1'b0;
		case (item.func)
			FUNC_TICK:  is_tick  = 1'b1;
			FUNC_SCHED: is_sched = 1'b1;
			FUNC_STOP:  is_stop  = 1'b1;
			default: ;
		endcase
	end

	assign next_cnt   = {1'b0, counter_q} + (TIME_W + 1)'(1);
	assign wrap       = next_cnt >= PERIOD;
	assign tick_cnt   = wrap ? '0 : next_cnt[TIME_W-1:0];
	assign cnt_d      = is_tick ? tick_cnt : counter_q;
	assign ch_ok      = 32'(item.channel) < CHANNELS;
	assign sched_ok   = is_sched && enable && (item.engine_rpm != '0) && ch_ok
		&& (item.target_time > counter_q) && ({1'b0, item.target_time} < PERIOD);
	assign stop_ok    = is_stop && enable && ch_ok;
	assign start_time = (item.target_time > TIME_W'(dwell))
		? item.target_time - TIME_W'(dwell) : '0;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i]      = 32'(item.channel) == 32'(i);
			forced_d[i] = forced_q[i];
			level_d[i]  = level_q[i];
			if (is_tick) begin
				// low action wins over dwell start, wrap counts as low
				if (forced_q[i] || wrap || spark_cmp_q[i] == tick_cnt) begin
					level_d[i] = 1'b0;
				end else if (dwell_cmp_q[i] == tick_cnt) begin
					level_d[i] = 1'b1;
				end
			end
			if (sched_ok && hit[i]) begin
				forced_d[i] = 1'b0;
			end
			if (stop_ok && hit[i]) begin
				forced_d[i] = 1'b1;
				level_d[i]  = 1'b0;
			end
		end
	end

	for (genvar j = 0; j < LEVELS_W; j++) begin : g_levels
		if (j < CHANNELS) begin : g_live
			assign levels[j] = level_d[j];
		end else begin : g_none
			assign levels[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			forced_q  <= '1;
			level_q   <= '0;
		end else if (go) begin
			counter_q <= cnt_d;
			forced_q  <= forced_d;
			level_q   <= level_d;
		end
	end

	// compares are only read once a schedule has released the channel
	always_ff @(posedge clk) begin
		for (int i = 0; i < CHANNELS; i++) begin
			if (go && sched_ok && hit[i]) begin
				dwell_cmp_q[i] <= start_time;
				spark_cmp_q[i] <= item.target_time;
			end
		end
	end

	assign result.accepted      = is_tick || sched_ok || stop_ok;
	assign result.coil_levels   = levels;
	assign result.dwell_used_us = sched_ok ? dwell : '0;
	assign result.counter_value = cnt_d;

endmodule
`default_nettype wire
